[hdl/usn_pkg.sv]
// ----------------------------------------------------------------------------
// usn_pkg
// Shared types and fixed constants of the unit surface normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package usn_pkg;

  // Edge and cross magnitudes are held below 2^30 after scaling
  localparam int unsigned MAG_W    = 30;
  localparam int unsigned EDGE_W   = MAG_W + 1;
  localparam int unsigned PROD_W   = 2 * EDGE_W;
  localparam int unsigned SQ_SUM_W = 62;
  // Square root datapath width and digit count
  localparam int unsigned SQ_W     = 63;
  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned ROOT_W   = 31;
  localparam int unsigned DIV_W    = ROOT_W + 1;
  localparam int unsigned OUT_W    = 16;

  typedef struct packed {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
  } out_t;

  // Side data carried through the square root cells
  typedef struct packed {
    logic [2:0][MAG_W-1:0] cm;
    logic [2:0]            neg;
    logic                  zero;
  } usn_pass_t;

  // Side data carried through the divider cells
  typedef struct packed {
    logic [DIV_W-1:0] div;
    logic [2:0]       neg;
    logic             zero;
  } usn_dpass_t;

endpackage

`default_nettype wire

[hdl/usn_front.sv]
// ----------------------------------------------------------------------------
// usn_front
// Edge vectors, edge scaling, cross product, cross scaling and sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module usn_front #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire usn_pkg::in_t                       in_data_i,
  output usn_pkg::usn_pass_t                      pass_o,
  output logic [usn_pkg::SQ_SUM_W-1:0]            sum_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int XW  = (CW > 32) ? CW : 32;
  localparam int MW  = usn_pkg::MAG_W;
  localparam int EW  = usn_pkg::EDGE_W;
  localparam int PW  = usn_pkg::PROD_W;

  function automatic logic signed [DW-1:0] coord(input logic [31:0] f);
    logic [XW-1:0] e;
    e = XW'(f);
    return DW'($signed(e[CW-1:0]));
  endfunction

  // Stage 1: edge differences
  logic signed [DW-1:0] a_d [3], a_q [3], b_d [3], b_q [3];

  always_comb begin
    a_d[0] = coord(in_data_i.first_x)  - coord(in_data_i.base_x);
    a_d[1] = coord(in_data_i.first_y)  - coord(in_data_i.base_y);
    a_d[2] = coord(in_data_i.first_z)  - coord(in_data_i.base_z);
    b_d[0] = coord(in_data_i.second_x) - coord(in_data_i.base_x);
    b_d[1] = coord(in_data_i.second_y) - coord(in_data_i.base_y);
    b_d[2] = coord(in_data_i.second_z) - coord(in_data_i.base_z);
  end

  // Stage 2: scale each edge below 2^30
  logic signed [EW-1:0] ea_d [3], ea_q [3], eb_d [3], eb_q [3];
  logic                 z2_d, z2_q;

  function automatic logic [DW-1:0] dmag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  always_comb begin
    logic [DW-1:0] ora, orb;
    int            pa, pb, sa, sb;
    logic [MW-1:0] m;
    ora = '0;
    orb = '0;
    pa  = 0;
    pb  = 0;
    for (int i = 0; i < 3; i++) begin
      ora = ora | dmag(a_q[i]);
      orb = orb | dmag(b_q[i]);
    end
    for (int k = 0; k < DW; k++) begin
      if (ora[k]) pa = k;
      if (orb[k]) pb = k;
    end
    sa = (pa >= MW) ? pa - (MW - 1) : 0;
    sb = (pb >= MW) ? pb - (MW - 1) : 0;
    for (int i = 0; i < 3; i++) begin
      m        = MW'(dmag(a_q[i]) >> sa);
      ea_d[i]  = a_q[i][DW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      m        = MW'(dmag(b_q[i]) >> sb);
      eb_d[i]  = b_q[i][DW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
    z2_d = (ora == '0) || (orb == '0);
  end

  // Stage 3: six partial products
  logic signed [PW-1:0] pr_d [6], pr_q [6];
  logic                 z3_q;

  always_comb begin
    pr_d[0] = PW'(ea_q[1]) * PW'(eb_q[2]);
    pr_d[1] = PW'(ea_q[2]) * PW'(eb_q[1]);
    pr_d[2] = PW'(ea_q[2]) * PW'(eb_q[0]);
    pr_d[3] = PW'(ea_q[0]) * PW'(eb_q[2]);
    pr_d[4] = PW'(ea_q[0]) * PW'(eb_q[1]);
    pr_d[5] = PW'(ea_q[1]) * PW'(eb_q[0]);
  end

  // Stage 4: cross product
  logic signed [PW-1:0] c_d [3], c_q [3];
  logic                 z4_q;

  always_comb begin
    c_d[0] = pr_q[0] - pr_q[1];
    c_d[1] = pr_q[2] - pr_q[3];
    c_d[2] = pr_q[4] - pr_q[5];
  end

  // Stage 5: bring the largest cross magnitude into [2^29, 2^30)
  usn_pkg::usn_pass_t p5_d, p5_q, p6_q, p7_q;

  always_comb begin
    logic [PW-1:0] m [3];
    logic [PW-1:0] orc;
    int            pc;
    orc = '0;
    pc  = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c_q[i][PW-1] ? PW'(-c_q[i]) : PW'(c_q[i]);
      orc  = orc | m[i];
    end
    for (int k = 0; k < PW; k++) begin
      if (orc[k]) pc = k;
    end
    for (int i = 0; i < 3; i++) begin
      if (pc >= MW - 1) begin
        p5_d.cm[i] = MW'(m[i] >> (pc - (MW - 1)));
      end else begin
        p5_d.cm[i] = MW'(m[i] << ((MW - 1) - pc));
      end
      p5_d.neg[i] = c_q[i][PW-1];
    end
    p5_d.zero = z4_q || (orc == '0);
  end

  // Stage 6: squares
  logic [2*MW-1:0] sq_d [3], sq_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = (2*MW)'(p5_q.cm[i]) * (2*MW)'(p5_q.cm[i]);
    end
  end

  // Stage 7: sum of squares
  logic [usn_pkg::SQ_SUM_W-1:0] sum_d, sum_q;

  assign sum_d = usn_pkg::SQ_SUM_W'(sq_q[0]) + usn_pkg::SQ_SUM_W'(sq_q[1])
               + usn_pkg::SQ_SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= a_d;
      b_q  <= b_d;
      ea_q <= ea_d;
      eb_q <= eb_d;
      z2_q <= z2_d;
      pr_q <= pr_d;
      z3_q <= z2_q;
      c_q  <= c_d;
      z4_q <= z3_q;
      p5_q <= p5_d;
      sq_q <= sq_d;
      p6_q <= p5_q;
      sum_q <= sum_d;
      p7_q <= p6_q;
    end
  end

  assign pass_o = p7_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

[hdl/usn_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// usn_sqrt_cell
// One digit of the integer square root; passes side data along.
// ----------------------------------------------------------------------------
`default_nettype none

module usn_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [usn_pkg::SQ_W-1:0] x_i,
  input  wire logic [usn_pkg::SQ_W-1:0] res_i,
  input  wire usn_pkg::usn_pass_t       pass_i,
  output logic [usn_pkg::SQ_W-1:0]      x_o,
  output logic [usn_pkg::SQ_W-1:0]      res_o,
  output usn_pkg::usn_pass_t            pass_o
);

  localparam int SW = usn_pkg::SQ_W;
  localparam logic [SW-1:0] BIT = SW'(1) << (SW - 1 - 2 * STEP);

  logic [SW-1:0] trial, x_d, res_d;

  always_comb begin
    trial = res_i + BIT;
    if (x_i >= trial) begin
      x_d   = x_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      x_d   = x_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      res_o  <= res_d;
      pass_o <= pass_i;
    end
  end

endmodule

`default_nettype wire

[hdl/usn_div_cell.sv]
// ----------------------------------------------------------------------------
// usn_div_cell
// One restoring division step for all three lanes; passes side data along.
// ----------------------------------------------------------------------------
`default_nettype none

module usn_div_cell #(
  parameter int QB = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [2:0][usn_pkg::DIV_W-1:0]      rem_i,
  input  wire logic [2:0][QB-1:0]                  nq_i,
  input  wire usn_pkg::usn_dpass_t                 dp_i,
  output logic [2:0][usn_pkg::DIV_W-1:0]           rem_o,
  output logic [2:0][QB-1:0]                       nq_o,
  output usn_pkg::usn_dpass_t                      dp_o
);

  localparam int DW = usn_pkg::DIV_W;

  logic [2:0][DW-1:0] rem_d;
  logic [2:0][QB-1:0] nq_d;

  always_comb begin
    logic [DW:0] t;
    logic        ge;
    for (int i = 0; i < 3; i++) begin
      t  = {rem_i[i], nq_i[i][QB-1]};
      ge = t >= {1'b0, dp_i.div};
      rem_d[i] = ge ? DW'(t - {1'b0, dp_i.div}) : DW'(t);
      nq_d[i]  = {nq_i[i][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      nq_o  <= nq_d;
      dp_o  <= dp_i;
    end
  end

endmodule

`default_nettype wire

[hdl/unit_surface_normal.sv]
// ----------------------------------------------------------------------------
// unit_surface_normal
// Unit normal of a triangle: Q16.16 points in, Q1.F unit vector out.
// ----------------------------------------------------------------------------
//
//  channel | direction | word                    | handshake
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | usn_pkg::in_t (9 x 32)  | in_valid_i / in_ready_o
//  out     | output    | usn_pkg::out_t (3 x 16) | out_valid_o / out_ready_o
//
//  One word per cycle sustained while the output accepts words. A word
//  passes seven front stages, 32 square root cells, NORMAL_FRAC_BITS + 2
//  divider cells and the output register.
//  Reset clears only the valid bits of the chain, the output and the skid.
//  A stall on the output fills the skid register with one more word; the
//  whole chain then holds until the skid drains.
// ----------------------------------------------------------------------------
`default_nettype none

module unit_surface_normal #(
  parameter int COORD_WIDTH      = 32,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire usn_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output usn_pkg::out_t      out_data_o
);

  localparam int F     = NORMAL_FRAC_BITS;
  localparam int QB    = F + 2;            // quotient bits, q < 2^(F+2)
  localparam int NW    = F + 32;           // numerator width
  localparam int NST   = 7 + usn_pkg::SQ_STEPS + QB;
  localparam int SW    = usn_pkg::SQ_W;
  localparam int DVW   = usn_pkg::DIV_W;

  // Output valid and skid valid; the chain enable reads the skid valid
  logic           out_valid_q, skid_v_q;

  // Chain enable: advance whenever the skid has room
  logic           en;
  logic [NST-1:0] vld_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Front stages
  usn_pkg::usn_pass_t            fpass;
  logic [usn_pkg::SQ_SUM_W-1:0]  fsum;

  usn_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .in_data_i (in_data_i),
    .pass_o    (fpass),
    .sum_o     (fsum)
  );

  // Square root chain, one digit per cell
  logic [SW-1:0]      sx   [usn_pkg::SQ_STEPS+1];
  logic [SW-1:0]      sres [usn_pkg::SQ_STEPS+1];
  usn_pkg::usn_pass_t spass[usn_pkg::SQ_STEPS+1];

  assign sx[0]    = SW'(fsum);
  assign sres[0]  = '0;
  assign spass[0] = fpass;

  for (genvar g = 0; g < usn_pkg::SQ_STEPS; g++) begin : g_sqrt
    usn_sqrt_cell #(
      .STEP(g)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (sx[g]),
      .res_i  (sres[g]),
      .pass_i (spass[g]),
      .x_o    (sx[g+1]),
      .res_o  (sres[g+1]),
      .pass_o (spass[g+1])
    );
  end

  // Divider set-up: numerator cm * 2^(F+1) + r over divisor 2r
  logic [usn_pkg::ROOT_W-1:0] root;
  logic [2:0][DVW-1:0]        drem [QB+1];
  logic [2:0][QB-1:0]         dnq  [QB+1];
  usn_pkg::usn_dpass_t        dpass[QB+1];

  assign root = usn_pkg::ROOT_W'(sres[usn_pkg::SQ_STEPS]);

  always_comb begin
    logic [NW-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num = (NW'(spass[usn_pkg::SQ_STEPS].cm[i]) << (F + 1)) + NW'(root);
      drem[0][i] = DVW'(num >> QB);
      dnq[0][i]  = QB'(num);
    end
    dpass[0].div  = {root, 1'b0};
    dpass[0].neg  = spass[usn_pkg::SQ_STEPS].neg;
    dpass[0].zero = spass[usn_pkg::SQ_STEPS].zero;
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    usn_div_cell #(
      .QB(QB)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (drem[g]),
      .nq_i  (dnq[g]),
      .dp_i  (dpass[g]),
      .rem_o (drem[g+1]),
      .nq_o  (dnq[g+1]),
      .dp_o  (dpass[g+1])
    );
  end

  // Clamp to one, apply sign, drop degenerate cases to zero
  localparam logic [QB-1:0] ONE = QB'(1) << F;
  usn_pkg::out_t res_w;

  always_comb begin
    logic [QB-1:0]        q;
    logic signed [QB-1:0] n [3];
    for (int i = 0; i < 3; i++) begin
      q    = dnq[QB][i];
      if (q > ONE) q = ONE;
      n[i] = dpass[QB].neg[i] ? -$signed(q) : $signed(q);
      if (dpass[QB].zero) n[i] = '0;
    end
    res_w.normal_x = usn_pkg::OUT_W'(n[0]);
    res_w.normal_y = usn_pkg::OUT_W'(n[1]);
    res_w.normal_z = usn_pkg::OUT_W'(n[2]);
  end

  // Output register with a skid word behind it
  usn_pkg::out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (en) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= vld_q[NST-1];
      end else if (vld_q[NST-1]) begin
        skid_v_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_valid_q || out_ready_i) begin
        out_q <= res_w;
      end else begin
        skid_q <= res_w;
      end
    end else if (out_ready_i) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A held skid word always has a waiting word ahead of it
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  // The skid only fills while the output is stalled
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid filled without an output stall");

  // Draining the skid keeps the output occupied
  a_skid_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && out_ready_i) |=> (out_valid_q && !skid_v_q))
    else $error("skid drain lost a word");

endmodule

`default_nettype wire
